>>> hw/rtl/lfb_pkg.sv
// Shared types and constants for the page-organized framebuffer line engine.
// Used by lfb_walk and line_draw_page_framebuffer_top. No dependencies.
package lfb_pkg;

    localparam int DEF_FRAME_WIDTH  = 128;
    localparam int DEF_FRAME_HEIGHT = 64;

    localparam int COORD_W     = 8;
    localparam int IDX_W       = 10;
    localparam int STEP_W      = 10;
    localparam int ERR_W       = 11;
    localparam int WIDE_ADDR_W = 14;
    localparam int WALK_LIMIT  = 512;

    localparam logic [1:0] CMD_LINE = 2'd0;
    localparam logic [1:0] CMD_FILL = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [7:0] FILL_CLEAR = 8'h00;
    localparam logic [7:0] FILL_SET   = 8'hFF;

    typedef struct packed {
        logic init;
        logic step;
    } walk_ctrl_t;

    typedef struct packed {
        logic at_end;
        logic at_limit;
    } walk_status_t;

endpackage

>>> hw/rtl/lfb_store.sv
// Byte-wide frame store: one write port and one read port with registered data.
// Depends on nothing; sized by the top level.
module lfb_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/lfb_walk.sv
// Bresenham error-term stepper: holds the current point, the end point and the
// error term, and advances one step on request. Depends on lfb_pkg.
module lfb_walk (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lfb_pkg::walk_ctrl_t          ctrl,
    input  logic [lfb_pkg::COORD_W-1:0]  x_start,
    input  logic [lfb_pkg::COORD_W-1:0]  y_start,
    input  logic [lfb_pkg::COORD_W-1:0]  x_end,
    input  logic [lfb_pkg::COORD_W-1:0]  y_end,
    output logic [lfb_pkg::COORD_W-1:0]  x_cur,
    output logic [lfb_pkg::COORD_W-1:0]  y_cur,
    output logic [lfb_pkg::COORD_W-1:0]  x_tgt,
    output logic [lfb_pkg::COORD_W-1:0]  y_tgt,
    output lfb_pkg::walk_status_t        status
);

    logic [lfb_pkg::COORD_W-1:0]      x_reg, y_reg, xe_reg, ye_reg;
    logic [lfb_pkg::COORD_W-1:0]      dx_reg, dy_reg;
    logic                             sx_reg, sy_reg;
    logic signed [lfb_pkg::ERR_W-1:0] err_reg;
    logic [lfb_pkg::STEP_W-1:0]       steps_reg;

    logic [lfb_pkg::COORD_W-1:0]      x_next, y_next, xe_next, ye_next;
    logic [lfb_pkg::COORD_W-1:0]      dx_next, dy_next;
    logic                             sx_next, sy_next;
    logic signed [lfb_pkg::ERR_W-1:0] err_next;
    logic [lfb_pkg::STEP_W-1:0]       steps_next;

    logic signed [lfb_pkg::ERR_W:0]   e2;
    logic signed [lfb_pkg::ERR_W:0]   dx_wide, dy_wide;
    logic                             move_x, move_y;

    assign e2      = {err_reg, 1'b0};
    assign dx_wide = $signed({4'b0000, dx_reg});
    assign dy_wide = $signed({4'b0000, dy_reg});
    assign move_x  = e2 > -dy_wide;
    assign move_y  = e2 < dx_wide;

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        xe_next    = xe_reg;
        ye_next    = ye_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        err_next   = err_reg;
        steps_next = steps_reg;
        if (ctrl.init)
        begin
            x_next     = x_start;
            y_next     = y_start;
            xe_next    = x_end;
            ye_next    = y_end;
            dx_next    = (x_end > x_start) ? x_end - x_start : x_start - x_end;
            dy_next    = (y_end > y_start) ? y_end - y_start : y_start - y_end;
            sx_next    = x_start < x_end;
            sy_next    = y_start < y_end;
            err_next   = $signed({3'b000, dx_next}) - $signed({3'b000, dy_next});
            steps_next = '0;
        end
        else if (ctrl.step)
        begin
            err_next = err_reg
                     - (move_x ? $signed({3'b000, dy_reg}) : '0)
                     + (move_y ? $signed({3'b000, dx_reg}) : '0);
            if (move_x)
            begin
                x_next = sx_reg ? x_reg + 8'd1 : x_reg - 8'd1;
            end
            if (move_y)
            begin
                y_next = sy_reg ? y_reg + 8'd1 : y_reg - 8'd1;
            end
            steps_next = steps_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= '0;
        end
        else
        begin
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        xe_reg  <= xe_next;
        ye_reg  <= ye_next;
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
        err_reg <= err_next;
    end

    assign x_cur           = x_reg;
    assign y_cur           = y_reg;
    assign x_tgt           = xe_reg;
    assign y_tgt           = ye_reg;
    assign status.at_end   = (x_reg == xe_reg) && (y_reg == ye_reg);
    assign status.at_limit = steps_reg == lfb_pkg::STEP_W'(lfb_pkg::WALK_LIMIT);

endmodule

>>> hw/rtl/line_draw_page_framebuffer_top.sv
// Top level of the page-organized monochrome framebuffer with a line engine.
// Depends on lfb_pkg, lfb_store and lfb_walk.
//
// Usage: commands arrive as beats on the s_ channel, command code in s_tuser.
// Each command returns exactly one beat on the m_ channel: the echoed command
// in m_tuser and, for a read, the byte in m_tdata (zero for other commands).
// Only one command is in flight: s_tready is high only while the sequencer is
// idle. The shared read-modify-write path and the Bresenham stepper set the
// timing. A line plots its end point first, then each point of the walk:
// an on-screen point is read, written back and tested for the end of the
// walk; an off-screen point is only tested. The longest line has 256
// points. A fill sweeps the store one byte per cycle, covering all
// FRAME_WIDTH*ceil(FRAME_HEIGHT/8) bytes (1024 by default). After reset
// the store is cleared by the same sweep, during which no command is
// taken. If the receiver stalls m_tready, the result stays in the output
// register and the sequencer waits with its next result until the
// register is free; a new command may still be accepted before that, but
// none while the sequencer waits.
module line_draw_page_framebuffer_top #(
    parameter int FRAME_WIDTH  = lfb_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = lfb_pkg::DEF_FRAME_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] x_start, [15:8] y_start, [23:16] x_end, [31:24] y_end,
    // [32] color, [42:33] byte_index, [47:43] zero
    input  logic [47:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_value
    output logic [7:0]  m_tdata,
    // [1:0] finished_command
    output logic [1:0]  m_tuser
);

    localparam int StoreBytes = FRAME_WIDTH * ((FRAME_HEIGHT + 7) / 8);
    localparam int AddrW      = $clog2(StoreBytes);
    localparam int WideW      = lfb_pkg::WIDE_ADDR_W;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_PLOT_RD,
        S_PLOT_WR,
        S_WALK,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [AddrW-1:0]        sweep_reg, sweep_next;
    logic                    report_reg, report_next;
    logic [7:0]              fill_reg, fill_next;
    logic [1:0]              cmd_reg, cmd_next;
    logic                    color_reg, color_next;
    logic [lfb_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                    plot_walk_reg, plot_walk_next;
    logic [AddrW-1:0]        pix_addr_reg, pix_addr_next;
    logic [2:0]              bit_reg, bit_next;
    logic [7:0]              res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    logic [7:0]              m_data_reg, m_data_next;
    logic [1:0]              m_user_reg, m_user_next;

    logic                    in_beat;
    logic [lfb_pkg::COORD_W-1:0] plot_x, plot_y;
    logic [lfb_pkg::COORD_W-1:0] x_cur, y_cur, x_tgt, y_tgt;
    logic                    on_screen;
    logic [WideW-1:0]        pix_addr_wide, read_addr_wide;
    logic                    read_in_range;
    logic [7:0]              bit_mask;

    lfb_pkg::walk_ctrl_t     walk_ctrl;
    lfb_pkg::walk_status_t   walk_status;

    logic                    wr_en, rd_en;
    logic [AddrW-1:0]        wr_addr, rd_addr;
    logic [7:0]              wr_data, rd_data;

    lfb_store #(
        .DEPTH  (StoreBytes),
        .ADDR_W (AddrW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lfb_walk u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (walk_ctrl),
        .x_start (s_tdata[7:0]),
        .y_start (s_tdata[15:8]),
        .x_end   (s_tdata[23:16]),
        .y_end   (s_tdata[31:24]),
        .x_cur   (x_cur),
        .y_cur   (y_cur),
        .x_tgt   (x_tgt),
        .y_tgt   (y_tgt),
        .status  (walk_status)
    );

    assign s_tready = state_reg == S_IDLE;
    assign in_beat  = s_tvalid && s_tready;

    // The end point is plotted first, then every point of the walk.
    assign plot_x    = plot_walk_reg ? x_cur : x_tgt;
    assign plot_y    = plot_walk_reg ? y_cur : y_tgt;
    assign on_screen = ({1'b0, plot_x} < 9'(FRAME_WIDTH)) &&
                       ({1'b0, plot_y} < 9'(FRAME_HEIGHT));
    assign pix_addr_wide  = WideW'(plot_x) + WideW'(plot_y[7:3]) * WideW'(FRAME_WIDTH);
    assign read_addr_wide = WideW'(idx_reg);
    assign read_in_range  = read_addr_wide < WideW'(StoreBytes);
    assign bit_mask       = 8'd1 << bit_reg;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        report_next    = report_reg;
        fill_next      = fill_reg;
        cmd_next       = cmd_reg;
        color_next     = color_reg;
        idx_next       = idx_reg;
        plot_walk_next = plot_walk_reg;
        pix_addr_next  = pix_addr_reg;
        bit_next       = bit_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        walk_ctrl      = '0;
        wr_en          = 1'b0;
        wr_addr        = pix_addr_reg;
        wr_data        = color_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
        rd_en          = 1'b0;
        rd_addr        = pix_addr_wide[AddrW-1:0];

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = sweep_reg;
                wr_data = fill_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == AddrW'(StoreBytes - 1))
                begin
                    sweep_next = '0;
                    state_next = report_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cmd_next   = s_tuser;
                    color_next = s_tdata[32];
                    idx_next   = s_tdata[42:33];
                    res_next   = '0;
                    case (s_tuser)
                        lfb_pkg::CMD_LINE:
                        begin
                            walk_ctrl.init = 1'b1;
                            plot_walk_next = 1'b0;
                            state_next     = S_PLOT_RD;
                        end
                        lfb_pkg::CMD_FILL:
                        begin
                            fill_next   = s_tdata[32] ? lfb_pkg::FILL_SET
                                                      : lfb_pkg::FILL_CLEAR;
                            report_next = 1'b1;
                            sweep_next  = '0;
                            state_next  = S_SWEEP;
                        end
                        lfb_pkg::CMD_READ:
                        begin
                            state_next = S_RD_ISSUE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_ISSUE:
            begin
                // A byte index beyond the store reads as zero.
                if (read_in_range)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = read_addr_wide[AddrW-1:0];
                    state_next = S_RD_DATA;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_DATA:
            begin
                res_next   = rd_data;
                state_next = S_DONE;
            end
            S_PLOT_RD:
            begin
                if (on_screen)
                begin
                    rd_en         = 1'b1;
                    pix_addr_next = pix_addr_wide[AddrW-1:0];
                    bit_next      = plot_y[2:0];
                    state_next    = S_PLOT_WR;
                end
                else
                begin
                    walk_ctrl.step = plot_walk_reg;
                    state_next     = S_WALK;
                end
            end
            S_PLOT_WR:
            begin
                wr_en          = 1'b1;
                walk_ctrl.step = plot_walk_reg;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                if (walk_status.at_end || walk_status.at_limit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    plot_walk_next = 1'b1;
                    state_next     = S_PLOT_RD;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_user_next  = cmd_reg;
                    report_next  = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            sweep_reg     <= '0;
            report_reg    <= 1'b0;
            fill_reg      <= lfb_pkg::FILL_CLEAR;
            cmd_reg       <= lfb_pkg::CMD_LINE;
            color_reg     <= 1'b0;
            idx_reg       <= '0;
            plot_walk_reg <= 1'b0;
            pix_addr_reg  <= '0;
            bit_reg       <= '0;
            res_reg       <= '0;
            m_valid_reg   <= 1'b0;
            m_data_reg    <= '0;
            m_user_reg    <= lfb_pkg::CMD_LINE;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            report_reg    <= report_next;
            fill_reg      <= fill_next;
            cmd_reg       <= cmd_next;
            color_reg     <= color_next;
            idx_reg       <= idx_next;
            plot_walk_reg <= plot_walk_next;
            pix_addr_reg  <= pix_addr_next;
            bit_reg       <= bit_next;
            res_reg       <= res_next;
            m_valid_reg   <= m_valid_next;
            m_data_reg    <= m_data_next;
            m_user_reg    <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTH
    a_wr_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (WideW'(wr_addr) < WideW'(StoreBytes)))
        else $error("store write beyond the last byte");

    a_plot_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLOT_WR) |-> ($past(state_reg) == S_PLOT_RD))
        else $error("pixel write without a preceding read");

    a_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != lfb_pkg::CMD_READ)) |-> (m_tdata == 8'h00))
        else $error("nonzero result for a command other than read");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        walk_ctrl.step |-> !walk_status.at_limit)
        else $error("walk stepped past its limit");
`endif

endmodule
